// ===== rtl/plrt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plrt_pkg
// Shared types and constants of the piecewise-linear RGBA transfer block.
// ----------------------------------------------------------------------------
package plrt_pkg;

    localparam int FRAC_W  = 16;
    localparam int COLOR_W = 48;
    localparam int CNT_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int NUM_W   = 32;
    localparam int LANES   = 4;
    localparam int COLOR_LANES = 3;
    localparam int ALPHA_LANE  = 3;
    localparam int STEP_W      = 4;

    localparam logic [FRAC_W-1:0] FRAC_ONE   = 16'hFFFF;
    localparam logic [16:0]       BYTE_RECIP = 17'd65281;

    typedef enum logic [1:0] {
        OP_WRITE_COLOR   = 2'd0,
        OP_WRITE_OPACITY = 2'd1,
        OP_EVALUATE      = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CFG_PREMULTIPLY   = 2'd0,
        CFG_COLOR_COUNT   = 2'd1,
        CFG_OPACITY_COUNT = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD,
        ST_DIVIDE,
        ST_PREMUL,
        ST_FOLD,
        ST_CORRECT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               color_we;
        logic               opacity_we;
        logic [3:0]         index;
        logic [FRAC_W-1:0]  position;
        logic [COLOR_W-1:0] color;
        logic [FRAC_W-1:0]  opacity;
    } point_write_t;

    typedef struct packed {
        logic               lock;
        logic               found;
        logic               direct;
        logic [FRAC_W-1:0]  s0;
        logic [FRAC_W-1:0]  s1;
        logic [FRAC_W-1:0]  prev_s;
        logic [COLOR_W-1:0] v0;
        logic [COLOR_W-1:0] v1;
        logic [COLOR_W-1:0] prev_v;
    } color_sel_t;

    typedef struct packed {
        logic              lock;
        logic              found;
        logic              direct;
        logic [FRAC_W-1:0] s0;
        logic [FRAC_W-1:0] s1;
        logic [FRAC_W-1:0] prev_s;
        logic [FRAC_W-1:0] v0;
        logic [FRAC_W-1:0] v1;
        logic [FRAC_W-1:0] prev_v;
    } opac_sel_t;

    typedef struct packed {
        logic [FRAC_W-1:0] t;
        color_sel_t        color;
        opac_sel_t         opac;
    } token_t;

    typedef logic [LANES-1:0][NUM_W-1:0]  lane_num_t;
    typedef logic [LANES-1:0][FRAC_W-1:0] lane_frac_t;
    typedef logic [LANES-1:0][BYTE_W-1:0] lane_byte_t;

endpackage
`default_nettype wire

// ===== rtl/plrt_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plrt_in_if
// Input channel: control point writes and evaluate requests.
// ----------------------------------------------------------------------------
interface plrt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  point_index;
    logic [15:0] position;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic [15:0] opacity_in;

    modport source
    (
        output valid, operation, point_index, position,
               red_in, green_in, blue_in, opacity_in,
        input  ready
    );

    modport sink
    (
        input  valid, operation, point_index, position,
               red_in, green_in, blue_in, opacity_in,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/plrt_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plrt_out_if
// Output channel: one RGBA byte beat per evaluate request.
// ----------------------------------------------------------------------------
interface plrt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_byte;
    logic [7:0] green_byte;
    logic [7:0] blue_byte;
    logic [7:0] alpha_byte;

    modport source
    (
        output valid, red_byte, green_byte, blue_byte, alpha_byte,
        input  ready
    );

    modport sink
    (
        input  valid, red_byte, green_byte, blue_byte, alpha_byte,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/piecewise_linear_rgba_transfer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_rgba_transfer_top
// Color and opacity ramps of control points evaluated into RGBA bytes.
// ----------------------------------------------------------------------------
// Each control point slot lives in its own cell of a chain of MAX_POINTS
// cells. A write beat lands in the addressed cell; writes to slots at or
// beyond MAX_POINTS are dropped. An evaluate beat sends a search token
// through the chain, one cell per cycle, then interpolates with a 16-step
// serial divider and converts to bytes; the input is held from the evaluate
// beat until its result sits in the output register. The next beat is
// taken once the result is there, even while it still waits to be taken.
// Configuration writes are expected only while no evaluation is in flight.
// ----------------------------------------------------------------------------
module piecewise_linear_rgba_transfer_top
    import plrt_pkg::*;
#(
    parameter int MAX_POINTS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    plrt_in_if.sink          item,
    plrt_out_if.source       result,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [CNT_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CW    = ($clog2(MAX_POINTS + 1) > CNT_W) ? $clog2(MAX_POINTS + 1) : CNT_W;

    function automatic logic [IDX_W-1:0] last_index(input logic [CNT_W-1:0] cnt);
        logic [CW-1:0] n;
        n = CW'(cnt);
        if (n == '0)
        begin
            n = CW'(1);
        end
        else if (n > CW'(MAX_POINTS))
        begin
            n = CW'(MAX_POINTS);
        end
        return IDX_W'(n - CW'(1));
    endfunction

    state_t             state_reg;
    state_t             state_next;
    logic               premul_reg;
    logic [CNT_W-1:0]   ccount_reg;
    logic [CNT_W-1:0]   ocount_reg;
    logic [IDX_W-1:0]   last_color;
    logic [IDX_W-1:0]   last_opac;

    logic               accept;
    logic               item_ready;
    logic               div_start;
    logic               load_num;
    logic               load_p;
    logic               load_e;
    logic               load_d;
    logic               out_load;
    logic               div_done;

    point_write_t       wr;
    token_t             chain_tok [MAX_POINTS+1];
    logic               chain_vld [MAX_POINTS+1];

    lane_num_t          num_reg;
    lane_num_t          num_next;
    lane_frac_t         den_reg;
    lane_frac_t         den_next;
    lane_frac_t         quot;
    lane_num_t          p_reg;
    lane_num_t          p_next;
    lane_frac_t         e_reg;
    lane_frac_t         e_next;
    lane_frac_t         d_reg;
    lane_frac_t         d_next;
    lane_byte_t         byte_reg;
    lane_byte_t         byte_next;
    logic               out_valid_reg;
    logic [LANES-1:0]   scale;

    assign accept     = item.valid && item_ready;
    assign item.ready = item_ready;
    assign last_color = last_index(ccount_reg);
    assign last_opac  = last_index(ocount_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            premul_reg <= 1'b0;
            ccount_reg <= CNT_W'(1);
            ocount_reg <= CNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_PREMULTIPLY:   premul_reg <= cfg_data[0];
                CFG_COLOR_COUNT:   ccount_reg <= cfg_data;
                CFG_OPACITY_COUNT: ocount_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        wr.color_we   = accept && (item.operation == OP_WRITE_COLOR);
        wr.opacity_we = accept && (item.operation == OP_WRITE_OPACITY);
        wr.index      = item.point_index;
        wr.position   = item.position;
        wr.color      = {item.red_in, item.green_in, item.blue_in};
        wr.opacity    = item.opacity_in;
    end

    always_comb
    begin
        chain_tok[0]   = '0;
        chain_tok[0].t = item.position;
        chain_vld[0]   = accept && (item.operation == OP_EVALUATE);
    end

    for (genvar k = 0; k < MAX_POINTS; k++)
    begin : g_cell
        plrt_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (k)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .wr            (wr),
            .last_color    (last_color),
            .last_opac     (last_opac),
            .tok_valid_in  (chain_vld[k]),
            .tok_in        (chain_tok[k]),
            .tok_valid_out (chain_vld[k+1]),
            .tok_out       (chain_tok[k+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.operation == OP_EVALUATE)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chain_vld[MAX_POINTS])
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:    state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_PREMUL;
                end
            end
            ST_PREMUL:  state_next = ST_FOLD;
            ST_FOLD:    state_next = ST_CORRECT;
            ST_CORRECT: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_ready = 1'b0;
        load_num   = 1'b0;
        div_start  = 1'b0;
        load_p     = 1'b0;
        load_e     = 1'b0;
        load_d     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:    item_ready = 1'b1;
            ST_SCAN:    load_num   = chain_vld[MAX_POINTS];
            ST_LOAD:    div_start  = 1'b1;
            ST_DIVIDE:  ;
            ST_PREMUL:  load_p     = 1'b1;
            ST_FOLD:    load_e     = 1'b1;
            ST_CORRECT: load_d     = 1'b1;
            ST_EMIT:    out_load   = !out_valid_reg || result.ready;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_load || (out_valid_reg && !result.ready);
        end
    end

    // Interpolation numerator and divisor; an end point divides by one.
    always_comb
    begin
        token_t            ct;
        logic [FRAC_W-1:0] c_hi;
        logic [FRAC_W-1:0] c_lo;
        logic [FRAC_W-1:0] o_hi;
        logic [FRAC_W-1:0] o_lo;
        logic [FRAC_W-1:0] v0;
        logic [FRAC_W-1:0] v1;
        ct   = chain_tok[MAX_POINTS];
        c_hi = ct.color.s1 - ct.t;
        c_lo = ct.t - ct.color.s0;
        o_hi = ct.opac.s1 - ct.t;
        o_lo = ct.t - ct.opac.s0;
        for (int ch = 0; ch < COLOR_LANES; ch++)
        begin
            v0 = ct.color.v0[(COLOR_LANES-1-ch)*FRAC_W +: FRAC_W];
            v1 = ct.color.v1[(COLOR_LANES-1-ch)*FRAC_W +: FRAC_W];
            num_next[ch] = ct.color.direct ? NUM_W'(v1)
                         : NUM_W'(v0) * NUM_W'(c_hi) + NUM_W'(v1) * NUM_W'(c_lo);
            den_next[ch] = ct.color.direct ? FRAC_W'(1) : ct.color.s1 - ct.color.s0;
        end
        num_next[ALPHA_LANE] = ct.opac.direct ? NUM_W'(ct.opac.v1)
                             : NUM_W'(ct.opac.v0) * NUM_W'(o_hi)
                               + NUM_W'(ct.opac.v1) * NUM_W'(o_lo);
        den_next[ALPHA_LANE] = ct.opac.direct ? FRAC_W'(1) : ct.opac.s1 - ct.opac.s0;
    end

    plrt_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    // Premultiplied bytes are floor(floor(c*a/65535)/257); the first step
    // estimates with a shift-add and corrects once, the second uses a
    // reciprocal multiply.
    always_comb
    begin
        logic [NUM_W:0]   fsum;
        logic [NUM_W:0]   r;
        logic [NUM_W:0]   prod;
        for (int l = 0; l < LANES; l++)
        begin
            scale[l] = premul_reg && (l != ALPHA_LANE);
            p_next[l] = scale[l] ? NUM_W'(quot[l]) * NUM_W'(quot[ALPHA_LANE])
                                 : NUM_W'(quot[l]);
            fsum = (NUM_W+1)'(p_reg[l]) + (NUM_W+1)'(p_reg[l] >> FRAC_W);
            e_next[l] = scale[l] ? fsum[NUM_W-1:FRAC_W] : p_reg[l][FRAC_W-1:0];
            r = (NUM_W+1)'(p_reg[l]) - (NUM_W+1)'({e_reg[l], {FRAC_W{1'b0}}})
              + (NUM_W+1)'(e_reg[l]);
            d_next[l] = (scale[l] && r >= (NUM_W+1)'(FRAC_ONE)) ? e_reg[l] + FRAC_W'(1)
                                                                 : e_reg[l];
            prod = (NUM_W+1)'(d_reg[l]) * (NUM_W+1)'(BYTE_RECIP);
            byte_next[l] = prod[NUM_W-1:NUM_W-BYTE_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_num)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
        if (load_p)
        begin
            p_reg <= p_next;
        end
        if (load_e)
        begin
            e_reg <= e_next;
        end
        if (load_d)
        begin
            d_reg <= d_next;
        end
        if (out_load)
        begin
            byte_reg <= byte_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.red_byte   = byte_reg[0];
    assign result.green_byte = byte_reg[1];
    assign result.blue_byte  = byte_reg[2];
    assign result.alpha_byte = byte_reg[ALPHA_LANE];

endmodule
`default_nettype wire

// ===== rtl/plrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plrt_cell
// One control point slot of both ramps; refines the search token as it passes.
// ----------------------------------------------------------------------------
module plrt_cell
    import plrt_pkg::*;
#(
    parameter int IDX_W      = 4,
    parameter int CELL_INDEX = 0
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire point_write_t     wr,
    input  wire logic [IDX_W-1:0] last_color,
    input  wire logic [IDX_W-1:0] last_opac,
    input  wire logic             tok_valid_in,
    input  wire token_t           tok_in,
    output logic                  tok_valid_out,
    output token_t                tok_out
);

    localparam int  WI    = (IDX_W > 4) ? IDX_W : 4;
    localparam bit  FIRST = (CELL_INDEX == 0);

    logic [FRAC_W-1:0]  cpos_reg;
    logic [COLOR_W-1:0] cval_reg;
    logic [FRAC_W-1:0]  opos_reg;
    logic [FRAC_W-1:0]  oval_reg;
    logic               tok_valid_reg;
    token_t             tok_reg;
    token_t             tok_next;
    logic               hit;
    logic               c_active;
    logic               o_active;
    logic               c_last;
    logic               o_last;

    assign hit      = (WI'(wr.index) == WI'(CELL_INDEX));
    assign c_last   = (last_color == IDX_W'(CELL_INDEX));
    assign o_last   = (last_opac == IDX_W'(CELL_INDEX));
    assign c_active = !tok_in.color.lock && (IDX_W'(CELL_INDEX) <= last_color);
    assign o_active = !tok_in.opac.lock && (IDX_W'(CELL_INDEX) <= last_opac);

    always_ff @(posedge clk)
    begin
        if (wr.color_we && hit)
        begin
            cpos_reg <= wr.position;
            cval_reg <= wr.color;
        end
        if (wr.opacity_we && hit)
        begin
            opos_reg <= wr.position;
            oval_reg <= wr.opacity;
        end
    end

    // A point at the ramp ends locks the result; otherwise the first point
    // at or above t closes the interpolation interval.
    always_comb
    begin
        tok_next              = tok_in;
        tok_next.color.prev_s = cpos_reg;
        tok_next.color.prev_v = cval_reg;
        tok_next.opac.prev_s  = opos_reg;
        tok_next.opac.prev_v  = oval_reg;

        if (c_active)
        begin
            if ((FIRST && tok_in.t <= cpos_reg) || (c_last && tok_in.t >= cpos_reg))
            begin
                tok_next.color.lock   = 1'b1;
                tok_next.color.direct = 1'b1;
                tok_next.color.v1     = cval_reg;
            end
            else if (!FIRST && !tok_in.color.found && tok_in.t <= cpos_reg)
            begin
                tok_next.color.found  = 1'b1;
                tok_next.color.direct = 1'b0;
                tok_next.color.s0     = tok_in.color.prev_s;
                tok_next.color.v0     = tok_in.color.prev_v;
                tok_next.color.s1     = cpos_reg;
                tok_next.color.v1     = cval_reg;
            end
        end

        if (o_active)
        begin
            if ((FIRST && tok_in.t <= opos_reg) || (o_last && tok_in.t >= opos_reg))
            begin
                tok_next.opac.lock   = 1'b1;
                tok_next.opac.direct = 1'b1;
                tok_next.opac.v1     = oval_reg;
            end
            else if (!FIRST && !tok_in.opac.found && tok_in.t <= opos_reg)
            begin
                tok_next.opac.found  = 1'b1;
                tok_next.opac.direct = 1'b0;
                tok_next.opac.s0     = tok_in.opac.prev_s;
                tok_next.opac.v0     = tok_in.opac.prev_v;
                tok_next.opac.s1     = opos_reg;
                tok_next.opac.v1     = oval_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule
`default_nettype wire

// ===== rtl/plrt_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plrt_divider
// Four-lane restoring divider, one quotient bit per lane each cycle.
// ----------------------------------------------------------------------------
module plrt_divider
    import plrt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire lane_num_t  num,
    input  wire lane_frac_t den,
    output logic            done,
    output lane_frac_t      quot
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] count_reg;
    lane_frac_t        rem_reg;
    lane_frac_t        quo_reg;
    lane_frac_t        rem_next;
    lane_frac_t        quo_next;

    // The quotient fits in a fraction, so the upper half of the dividend
    // starts below the divisor.
    always_comb
    begin
        logic [FRAC_W:0] sh;
        logic            ge;
        for (int l = 0; l < LANES; l++)
        begin
            sh          = {rem_reg[l], quo_reg[l][FRAC_W-1]};
            ge          = (sh >= {1'b0, den[l]});
            rem_next[l] = ge ? FRAC_W'(sh - {1'b0, den[l]}) : sh[FRAC_W-1:0];
            quo_next[l] = {quo_reg[l][FRAC_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (count_reg == {STEP_W{1'b1}});
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + STEP_W'(1);
                if (count_reg == {STEP_W{1'b1}})
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[l] <= num[l][NUM_W-1:FRAC_W];
                quo_reg[l] <= num[l][FRAC_W-1:0];
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule
`default_nettype wire
